@@ rtl/plcl_pkg.sv @@
`default_nettype none
package plcl_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int DATA_W          = 32;
    localparam int CNT_W           = 17;
    localparam int DIV_STEPS       = 66;

    localparam logic [1:0] ST_ANSWER    = 2'd0;
    localparam logic [1:0] ST_NOT_READY = 2'd1;
    localparam logic [1:0] ST_WRITTEN   = 2'd2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] CFG_POINTS    = 2'd0;
    localparam logic [1:0] CFG_INTERCEPT = 2'd1;
    localparam logic [1:0] CFG_SLOPE     = 2'd2;
    localparam logic [1:0] CFG_READY     = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_LAST_RD, S_LAST_CHK, S_ONE_RD, S_SRCH, S_SRCH_CMP,
        S_LOAD_A, S_LOAD_B, S_TAIL_MUL, S_TAIL_ADD, S_LERP_MUL,
        S_DIV_INIT, S_DIV, S_LERP_ADD, S_FINISH
    } state_t;

    typedef enum logic [2:0] {
        ADDR_LAST, ADDR_ZERO, ADDR_MID, ADDR_A, ADDR_B
    } addr_sel_t;

    typedef struct packed {
        logic      load_item;
        logic      wr_entry;
        addr_sel_t addr_sel;
        logic      load_last;
        logic      one_load;
        logic      srch_init;
        logic      srch_step;
        logic      load_a;
        logic      load_b;
        logic      tail_mul;
        logic      tail_add;
        logic      lerp_mul;
        logic      div_start;
        logic      div_step;
        logic      lerp_add;
        logic      chan_next;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        logic tbl_ready;
        logic tail_hit;
        logic single;
        logic srch_done;
        logic div_done;
        logic chan_kk;
    } sts_t;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [67:0] hi;
        logic signed [67:0] lo;
        hi = 68'sh7FFFFFFF;
        lo = -68'sh80000000;
        if (v > hi) begin
            sat32 = 32'sh7FFFFFFF;
        end else if (v < lo) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

endpackage
`default_nettype wire

@@ rtl/plcl_ram.sv @@
`default_nettype none
module plcl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

@@ rtl/plcl_ctrl.sv @@
`default_nettype none
module plcl_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic          s_operation,
    output logic               m_valid,
    input  wire logic          m_ready,
    input  wire plcl_pkg::sts_t sts,
    output plcl_pkg::cmd_t     cmd
);
    import plcl_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign s_ready  = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_operation == OP_WRITE || !sts.tbl_ready) begin
                        state_next = S_FINISH;
                    end else begin
                        state_next = S_LAST_RD;
                    end
                end
            end
            S_LAST_RD:  state_next = S_LAST_CHK;
            S_LAST_CHK: begin
                if (sts.tail_hit) begin
                    state_next = S_TAIL_MUL;
                end else if (sts.single) begin
                    state_next = S_ONE_RD;
                end else begin
                    state_next = S_SRCH;
                end
            end
            S_ONE_RD:   state_next = S_FINISH;
            S_SRCH:     state_next = sts.srch_done ? S_LOAD_A : S_SRCH_CMP;
            S_SRCH_CMP: state_next = S_SRCH;
            S_LOAD_A:   state_next = S_LOAD_B;
            S_LOAD_B:   state_next = S_LERP_MUL;
            S_TAIL_MUL: state_next = S_TAIL_ADD;
            S_TAIL_ADD: state_next = S_FINISH;
            S_LERP_MUL: state_next = S_DIV_INIT;
            S_DIV_INIT: state_next = S_DIV;
            S_DIV:      state_next = sts.div_done ? S_LERP_ADD : S_DIV;
            S_LERP_ADD: state_next = sts.chan_kk ? S_FINISH : S_LERP_MUL;
            S_FINISH:   state_next = out_free ? S_IDLE : S_FINISH;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.addr_sel = ADDR_LAST;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            S_IDLE: begin
                cmd.load_item = s_valid;
                cmd.wr_entry  = s_valid && (s_operation == OP_WRITE);
            end
            S_LAST_RD: cmd.addr_sel = ADDR_LAST;
            S_LAST_CHK: begin
                cmd.load_last = sts.tail_hit;
                cmd.srch_init = !sts.tail_hit && !sts.single;
                cmd.addr_sel  = ADDR_ZERO;
            end
            S_ONE_RD: cmd.one_load = 1'b1;
            S_SRCH:   cmd.addr_sel = sts.srch_done ? ADDR_A : ADDR_MID;
            S_SRCH_CMP: cmd.srch_step = 1'b1;
            S_LOAD_A: begin
                cmd.load_a   = 1'b1;
                cmd.addr_sel = ADDR_B;
            end
            S_LOAD_B:   cmd.load_b = 1'b1;
            S_TAIL_MUL: cmd.tail_mul = 1'b1;
            S_TAIL_ADD: cmd.tail_add = 1'b1;
            S_LERP_MUL: cmd.lerp_mul = 1'b1;
            S_DIV_INIT: cmd.div_start = 1'b1;
            S_DIV:      cmd.div_step = !sts.div_done;
            S_LERP_ADD: begin
                cmd.lerp_add  = 1'b1;
                cmd.chan_next = !sts.chan_kk;
            end
            S_FINISH: begin
                cmd.out_load = out_free;
                if (out_free) begin
                    m_valid_next = 1'b1;
                end
            end
            default: cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

@@ rtl/plcl_dp.sv @@
`default_nettype none
module plcl_dp #(
    parameter int TABLE_DEPTH = plcl_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire plcl_pkg::cmd_t     cmd,
    output plcl_pkg::sts_t          sts,
    input  wire logic               cfg_valid,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               s_operation,
    input  wire logic [9:0]         s_entry_index,
    input  wire logic [30:0]        s_entry_voltage,
    input  wire logic [30:0]        s_entry_dc_current,
    input  wire logic signed [31:0] s_entry_kk_current,
    input  wire logic signed [31:0] s_query_voltage,
    output logic [1:0]              m_status,
    output logic signed [31:0]      m_dc_current,
    output logic signed [31:0]      m_kk_current
);
    import plcl_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    logic [10:0]        points_reg;
    logic signed [31:0] icpt_reg;
    logic signed [31:0] slope_reg;
    logic               ready_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            points_reg <= 11'd1;
            icpt_reg   <= '0;
            slope_reg  <= 32'sd65536;
            ready_reg  <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_POINTS:    points_reg <= cfg_data[10:0];
                CFG_INTERCEPT: icpt_reg   <= cfg_data;
                CFG_SLOPE:     slope_reg  <= cfg_data;
                CFG_READY:     ready_reg  <= cfg_data[0];
                default:       ready_reg  <= ready_reg;
            endcase
        end
    end

    logic [CNT_W-1:0] pts_ext, n_cnt, idx_ext;
    logic [AW-1:0]    nm1;
    always_comb begin
        pts_ext = CNT_W'(points_reg);
        if (pts_ext == '0) begin
            n_cnt = CNT_W'(1);
        end else if (pts_ext > DEPTH_C) begin
            n_cnt = DEPTH_C;
        end else begin
            n_cnt = pts_ext;
        end
        nm1     = AW'(n_cnt - CNT_W'(1));
        idx_ext = CNT_W'(s_entry_index);
    end

    logic [AW-1:0] a_reg, b_reg, mid;
    assign mid = a_reg + AW'((b_reg - a_reg) >> 1);

    logic [AW-1:0]  ram_addr;
    logic           ram_we;
    logic [31:0]    rd_v, rd_dc, rd_kk;
    always_comb begin
        ram_we = cmd.wr_entry && (idx_ext < DEPTH_C);
        if (cmd.wr_entry) begin
            ram_addr = idx_ext[AW-1:0];
        end else begin
            case (cmd.addr_sel)
                ADDR_LAST: ram_addr = nm1;
                ADDR_ZERO: ram_addr = '0;
                ADDR_MID:  ram_addr = mid;
                ADDR_A:    ram_addr = a_reg;
                ADDR_B:    ram_addr = b_reg;
                default:   ram_addr = nm1;
            endcase
        end
    end

    plcl_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_volt (
        .aclk(aclk), .we(ram_we), .addr(ram_addr),
        .wdata({1'b0, s_entry_voltage}), .rdata(rd_v));
    plcl_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_dc (
        .aclk(aclk), .we(ram_we), .addr(ram_addr),
        .wdata({1'b0, s_entry_dc_current}), .rdata(rd_dc));
    plcl_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_kk (
        .aclk(aclk), .we(ram_we), .addr(ram_addr),
        .wdata(s_entry_kk_current), .rdata(rd_kk));

    logic [32:0]        mag_reg;
    logic               neg_reg;
    logic [1:0]         status_reg;
    logic signed [31:0] dc_reg, kk_reg;
    logic [31:0]        xa_reg, xb_reg, ya_dc_reg, yb_dc_reg, ya_kk_reg, yb_kk_reg;
    logic               chan_reg;
    logic signed [66:0] prod_reg;
    logic signed [65:0] tprod_reg;
    logic [65:0]        quo_reg;
    logic [31:0]        rem_reg, den_reg;
    logic               qneg_reg;
    logic [6:0]         cnt_reg;

    logic signed [32:0] vq;
    logic [32:0]        mag_in;
    logic               lt_mid;
    logic signed [33:0] ya_sel, yb_sel, dy;
    logic signed [32:0] dxx, dx;
    logic [66:0]        prod_abs;
    logic [32:0]        dx_abs;
    logic [32:0]        rem_s;
    logic               ge;
    logic signed [67:0] sum, qs, tsum;
    logic signed [31:0] lerp_res, dc_out;

    always_comb begin
        vq       = {s_query_voltage[31], s_query_voltage};
        mag_in   = vq[32] ? 33'(-vq) : 33'(vq);
        lt_mid   = {1'b0, rd_v} < mag_reg;
        ya_sel   = chan_reg ? 34'(signed'(ya_kk_reg)) : 34'(signed'({1'b0, ya_dc_reg}));
        yb_sel   = chan_reg ? 34'(signed'(yb_kk_reg)) : 34'(signed'({1'b0, yb_dc_reg}));
        dy       = yb_sel - ya_sel;
        dxx      = signed'(mag_reg) - signed'({1'b0, xa_reg});
        dx       = signed'({1'b0, xb_reg}) - signed'({1'b0, xa_reg});
        prod_abs = prod_reg[66] ? 67'(-prod_reg) : 67'(prod_reg);
        dx_abs   = dx[32] ? 33'(-dx) : 33'(dx);
        rem_s    = {rem_reg, quo_reg[65]};
        ge       = rem_s >= {1'b0, den_reg};
        qs       = signed'({2'b00, quo_reg});
        sum      = 68'(ya_sel) + (qneg_reg ? -qs : qs);
        lerp_res = (dx == '0) ? ya_sel[31:0] : sat32(sum);
        tsum     = 68'(signed'(tprod_reg[65:16])) + 68'(icpt_reg);
        if (neg_reg && status_reg == ST_ANSWER) begin
            dc_out = (dc_reg == 32'sh80000000) ? 32'sh7FFFFFFF : -dc_reg;
        end else begin
            dc_out = dc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            mag_reg <= mag_in;
            neg_reg <= vq[32];
            dc_reg  <= '0;
            kk_reg  <= '0;
            if (s_operation == OP_WRITE) begin
                status_reg <= ST_WRITTEN;
            end else if (!ready_reg) begin
                status_reg <= ST_NOT_READY;
            end else begin
                status_reg <= ST_ANSWER;
            end
        end
        if (cmd.load_last) begin
            kk_reg <= rd_kk;
        end
        if (cmd.one_load) begin
            dc_reg <= rd_dc;
            kk_reg <= rd_kk;
        end
        if (cmd.srch_init) begin
            a_reg <= '0;
            b_reg <= nm1;
        end
        if (cmd.srch_step) begin
            if (lt_mid) begin
                a_reg <= mid;
            end else begin
                b_reg <= mid;
            end
        end
        if (cmd.load_a) begin
            xa_reg    <= rd_v;
            ya_dc_reg <= rd_dc;
            ya_kk_reg <= rd_kk;
        end
        if (cmd.load_b) begin
            xb_reg    <= rd_v;
            yb_dc_reg <= rd_dc;
            yb_kk_reg <= rd_kk;
            chan_reg  <= 1'b0;
        end
        if (cmd.tail_mul) begin
            tprod_reg <= slope_reg * signed'({1'b0, mag_reg});
        end
        if (cmd.tail_add) begin
            dc_reg <= sat32(tsum);
        end
        if (cmd.lerp_mul) begin
            prod_reg <= dy * dxx;
        end
        if (cmd.div_start) begin
            quo_reg  <= prod_abs[65:0];
            den_reg  <= dx_abs[31:0];
            rem_reg  <= '0;
            qneg_reg <= prod_reg[66] ^ dx[32];
            cnt_reg  <= 7'(DIV_STEPS);
        end
        if (cmd.div_step) begin
            rem_reg <= ge ? 32'(rem_s - {1'b0, den_reg}) : rem_s[31:0];
            quo_reg <= {quo_reg[64:0], ge};
            cnt_reg <= cnt_reg - 7'd1;
        end
        if (cmd.lerp_add) begin
            if (chan_reg) begin
                kk_reg <= lerp_res;
            end else begin
                dc_reg <= lerp_res;
            end
        end
        if (cmd.chan_next) begin
            chan_reg <= 1'b1;
        end
        if (cmd.out_load) begin
            m_status     <= status_reg;
            m_dc_current <= dc_out;
            m_kk_current <= kk_reg;
        end
    end

    always_comb begin
        sts.tbl_ready = ready_reg;
        sts.tail_hit  = mag_reg >= {1'b0, rd_v};
        sts.single    = (nm1 == '0);
        sts.srch_done = (AW'(b_reg - a_reg) <= AW'(1));
        sts.div_done  = (cnt_reg == '0);
        sts.chan_kk   = chan_reg;
    end
endmodule
`default_nettype wire

@@ rtl/piecewise_linear_curve_lookup_top.sv @@
`default_nettype none
// Piecewise-linear curve lookup over a table of breakpoints in Q16.16.
// The input channel (s_) carries one beat per item: a table write when
// s_operation is 0, a voltage query when it is 1. Every item yields exactly
// one result beat on the m_ channel with a status, a DC current and a KK
// current. Registers are to be written by the user over the cfg_ channel
// only while the block idles; the block itself does not enforce this.
// A write or a not-ready query goes straight to the output register. A query
// reads the single entry, extends the tail by slope and intercept, or
// interpolates; the shared divider, run once per current, retires one of 66 quotient bits per cycle.
// The block works on one item at a time; a new item is taken as soon as the
// previous one has reached the output register.
// When the receiver stalls, the result holds in the output register and the
// next item still computes, waiting at its end until the register frees.
// Reset clears the control state and loads the register defaults; table
// contents are undefined until written.
module piecewise_linear_curve_lookup_top #(
    parameter int TABLE_DEPTH = plcl_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_operation,
    input  wire logic [9:0]         s_entry_index,
    input  wire logic [30:0]        s_entry_voltage,
    input  wire logic [30:0]        s_entry_dc_current,
    input  wire logic signed [31:0] s_entry_kk_current,
    input  wire logic signed [31:0] s_query_voltage,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_status,
    output logic signed [31:0]      m_dc_current,
    output logic signed [31:0]      m_kk_current
);
    import plcl_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    plcl_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .m_valid(m_valid), .m_ready(m_ready),
        .sts(sts), .cmd(cmd)
    );

    plcl_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_operation(s_operation), .s_entry_index(s_entry_index),
        .s_entry_voltage(s_entry_voltage), .s_entry_dc_current(s_entry_dc_current),
        .s_entry_kk_current(s_entry_kk_current), .s_query_voltage(s_query_voltage),
        .m_status(m_status), .m_dc_current(m_dc_current), .m_kk_current(m_kk_current)
    );
endmodule
`default_nettype wire
